FILE: design/i2cee_pkg.sv
// Shared types, phase codes and constants for the two-wire EEPROM master.
package i2cee_pkg;

  localparam int MAX_BURST = 32;
  localparam int BL_W      = $clog2(MAX_BURST + 1);

  localparam logic [6:0] DEVICE_CODE_RST = 7'd80;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_DATA  = 2'd3;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_START_A = 5'd1;
  localparam logic [4:0] PH_START_B = 5'd2;
  localparam logic [4:0] PH_START_C = 5'd3;
  localparam logic [4:0] PH_TX_LO   = 5'd4;
  localparam logic [4:0] PH_TX_HI   = 5'd5;
  localparam logic [4:0] PH_TACK_LO = 5'd6;
  localparam logic [4:0] PH_TACK_HI = 5'd7;
  localparam logic [4:0] PH_RS_LO   = 5'd8;
  localparam logic [4:0] PH_RS_HI   = 5'd9;
  localparam logic [4:0] PH_RX_LO   = 5'd10;
  localparam logic [4:0] PH_RX_HI   = 5'd11;
  localparam logic [4:0] PH_MACK_LO = 5'd12;
  localparam logic [4:0] PH_MACK_HI = 5'd13;
  localparam logic [4:0] PH_NACK_LO = 5'd14;
  localparam logic [4:0] PH_NACK_HI = 5'd15;
  localparam logic [4:0] PH_STOP_A  = 5'd16;
  localparam logic [4:0] PH_STOP_B  = 5'd17;
  localparam logic [4:0] PH_STOP_C  = 5'd18;
  localparam logic [4:0] PH_WAIT    = 5'd19;

  localparam logic [2:0] HDR_CTRL_W  = 3'd0;
  localparam logic [2:0] HDR_ADDR_HI = 3'd1;
  localparam logic [2:0] HDR_ADDR_LO = 3'd2;
  localparam logic [2:0] HDR_CTRL_R  = 3'd3;
  localparam logic [2:0] HDR_DATA    = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] mem_address;
    logic [7:0]  write_byte;
    logic [5:0]  byte_count;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       data_request;
    logic       read_valid;
    logic [7:0] read_data;
    logic       last_of_burst;
  } res_t;

endpackage

FILE: design/i2cee_fsm.sv
// Bus phase sequencer: transaction state and one-phase-per-item next-state logic.
module i2cee_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  i2cee_pkg::item_t    item,
  input  logic [6:0]          device_code,
  output i2cee_pkg::res_t     res
);

  logic [4:0]                phase_r, phase_nxt;
  logic [2:0]                bit_idx_r, bit_idx_nxt;
  logic [7:0]                shift_r, shift_nxt;
  logic [i2cee_pkg::BL_W-1:0] left_r, left_nxt;
  logic [15:0]               addr_r, addr_nxt;
  logic                      is_read_r, is_read_nxt;
  logic [2:0]                hdr_r, hdr_nxt;

  always_comb begin
    logic [6:0] cnt;
    logic [4:0] ph;

    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    addr_nxt    = addr_r;
    is_read_nxt = is_read_r;
    hdr_nxt     = hdr_r;
    res         = '0;
    res.scl_level = 1'b1;
    res.busy_res  = 1'b1;

    cnt = {1'b0, item.byte_count};
    if (cnt == 7'd0) cnt = 7'd1;
    if (cnt > 7'(i2cee_pkg::MAX_BURST)) cnt = 7'(i2cee_pkg::MAX_BURST);

    // begin a burst or take the requested write byte before emitting this phase
    if (phase_r == i2cee_pkg::PH_IDLE &&
        (item.action == i2cee_pkg::ACT_READ || item.action == i2cee_pkg::ACT_WRITE)) begin
      left_nxt    = i2cee_pkg::BL_W'(cnt);
      addr_nxt    = item.mem_address;
      is_read_nxt = (item.action == i2cee_pkg::ACT_READ);
      hdr_nxt     = i2cee_pkg::HDR_CTRL_W;
      bit_idx_nxt = 3'd0;
      phase_nxt   = i2cee_pkg::PH_START_A;
    end else if (phase_r == i2cee_pkg::PH_WAIT && item.action == i2cee_pkg::ACT_DATA) begin
      hdr_nxt     = i2cee_pkg::HDR_DATA;
      shift_nxt   = item.write_byte;
      bit_idx_nxt = 3'd7;
      phase_nxt   = i2cee_pkg::PH_TX_LO;
    end

    ph = phase_nxt;
    case (ph)
      i2cee_pkg::PH_START_A: begin
        phase_nxt = i2cee_pkg::PH_START_B;
      end
      i2cee_pkg::PH_START_B: begin
        res.sda_pull_low = 1'b1;
        phase_nxt = i2cee_pkg::PH_START_C;
      end
      i2cee_pkg::PH_START_C: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = 1'b1;
        shift_nxt   = {device_code, hdr_nxt == i2cee_pkg::HDR_CTRL_R};
        bit_idx_nxt = 3'd7;
        phase_nxt   = i2cee_pkg::PH_TX_LO;
      end
      i2cee_pkg::PH_TX_LO: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = ~shift_nxt[bit_idx_nxt];
        phase_nxt = i2cee_pkg::PH_TX_HI;
      end
      i2cee_pkg::PH_TX_HI: begin
        res.sda_pull_low = ~shift_nxt[bit_idx_nxt];
        if (bit_idx_nxt == 3'd0) begin
          phase_nxt = i2cee_pkg::PH_TACK_LO;
        end else begin
          bit_idx_nxt = bit_idx_nxt - 3'd1;
          phase_nxt   = i2cee_pkg::PH_TX_LO;
        end
      end
      i2cee_pkg::PH_TACK_LO: begin
        res.scl_level = 1'b0;
        phase_nxt = i2cee_pkg::PH_TACK_HI;
      end
      i2cee_pkg::PH_TACK_HI: begin
        // slave ack is clocked but ignored; pick the next header byte, or go on to restart, data wait, read or stop
        case (hdr_nxt)
          i2cee_pkg::HDR_CTRL_W: begin
            hdr_nxt     = i2cee_pkg::HDR_ADDR_HI;
            shift_nxt   = addr_nxt[15:8];
            bit_idx_nxt = 3'd7;
            phase_nxt   = i2cee_pkg::PH_TX_LO;
          end
          i2cee_pkg::HDR_ADDR_HI: begin
            hdr_nxt     = i2cee_pkg::HDR_ADDR_LO;
            shift_nxt   = addr_nxt[7:0];
            bit_idx_nxt = 3'd7;
            phase_nxt   = i2cee_pkg::PH_TX_LO;
          end
          i2cee_pkg::HDR_ADDR_LO: begin
            if (is_read_nxt) begin
              phase_nxt = i2cee_pkg::PH_RS_LO;
            end else begin
              hdr_nxt   = i2cee_pkg::HDR_DATA;
              phase_nxt = i2cee_pkg::PH_WAIT;
            end
          end
          i2cee_pkg::HDR_CTRL_R: begin
            shift_nxt   = 8'd0;
            bit_idx_nxt = 3'd7;
            phase_nxt   = i2cee_pkg::PH_RX_LO;
          end
          default: begin
            if (left_nxt != '0) left_nxt = left_nxt - i2cee_pkg::BL_W'(1);
            phase_nxt = (left_nxt != '0) ? i2cee_pkg::PH_WAIT : i2cee_pkg::PH_STOP_A;
          end
        endcase
      end
      i2cee_pkg::PH_RS_LO: begin
        res.scl_level = 1'b0;
        phase_nxt = i2cee_pkg::PH_RS_HI;
      end
      i2cee_pkg::PH_RS_HI: begin
        hdr_nxt   = i2cee_pkg::HDR_CTRL_R;
        phase_nxt = i2cee_pkg::PH_START_B;
      end
      i2cee_pkg::PH_RX_LO: begin
        res.scl_level = 1'b0;
        phase_nxt = i2cee_pkg::PH_RX_HI;
      end
      i2cee_pkg::PH_RX_HI: begin
        shift_nxt[bit_idx_nxt] = shift_nxt[bit_idx_nxt] | item.sda_in;
        if (bit_idx_nxt == 3'd0) begin
          res.read_valid    = 1'b1;
          res.read_data     = shift_nxt;
          res.last_of_burst = (left_nxt <= i2cee_pkg::BL_W'(1));
          if (left_nxt != '0) left_nxt = left_nxt - i2cee_pkg::BL_W'(1);
          phase_nxt = (left_nxt != '0) ? i2cee_pkg::PH_MACK_LO : i2cee_pkg::PH_NACK_LO;
        end else begin
          bit_idx_nxt = bit_idx_nxt - 3'd1;
          phase_nxt   = i2cee_pkg::PH_RX_LO;
        end
      end
      i2cee_pkg::PH_MACK_LO: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = 1'b1;
        phase_nxt = i2cee_pkg::PH_MACK_HI;
      end
      i2cee_pkg::PH_MACK_HI: begin
        res.sda_pull_low = 1'b1;
        shift_nxt   = 8'd0;
        bit_idx_nxt = 3'd7;
        phase_nxt   = i2cee_pkg::PH_RX_LO;
      end
      i2cee_pkg::PH_NACK_LO: begin
        res.scl_level = 1'b0;
        phase_nxt = i2cee_pkg::PH_NACK_HI;
      end
      i2cee_pkg::PH_NACK_HI: begin
        phase_nxt = i2cee_pkg::PH_STOP_A;
      end
      i2cee_pkg::PH_STOP_A: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = 1'b1;
        phase_nxt = i2cee_pkg::PH_STOP_B;
      end
      i2cee_pkg::PH_STOP_B: begin
        res.sda_pull_low = 1'b1;
        phase_nxt = i2cee_pkg::PH_STOP_C;
      end
      i2cee_pkg::PH_STOP_C: begin
        bit_idx_nxt = 3'd0;
        phase_nxt   = i2cee_pkg::PH_IDLE;
      end
      i2cee_pkg::PH_WAIT: begin
        res.scl_level     = 1'b0;
        res.data_request  = 1'b1;
        res.last_of_burst = (left_nxt <= i2cee_pkg::BL_W'(1));
      end
      default: begin
        res.busy_res = 1'b0;
        phase_nxt    = i2cee_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cee_pkg::PH_IDLE;
      bit_idx_r <= 3'd0;
      shift_r   <= 8'd0;
      left_r    <= '0;
      addr_r    <= 16'd0;
      is_read_r <= 1'b0;
      hdr_r     <= i2cee_pkg::HDR_CTRL_W;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      left_r    <= left_nxt;
      addr_r    <= addr_nxt;
      is_read_r <= is_read_nxt;
      hdr_r     <= hdr_nxt;
    end
  end

endmodule

FILE: design/i2c_eeprom_bus_master_core.sv
// Two-wire EEPROM master top level: input register, phase sequencer, result register.
// Timing: an accepted item waits in the input register; when it fires, the result register
// loads the sequencer's result and out_valid rises. A stalled result can delay the fire.
// Throughput: one item per cycle unless stalled; each item moves the sequencer one bus phase.
// A stalled result holds the result register and backs up into the input register.
// Reset (rst_n low, synchronous) returns the bus to idle and device_code to 80.
// The configuration port is always ready; write it only while the bus is idle.
module i2c_eeprom_bus_master_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_mem_address,
  input  logic [7:0]  in_write_byte,
  input  logic [5:0]  in_byte_count,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_pull_low,
  output logic        out_busy_res,
  output logic        out_data_request,
  output logic        out_read_valid,
  output logic [7:0]  out_read_data,
  output logic        out_last_of_burst
);

  logic             cfg_wr;
  logic [6:0]       device_code_r;
  logic             in_vld_r;
  i2cee_pkg::item_t item_r;
  logic             out_vld_r;
  i2cee_pkg::res_t  res_r;
  i2cee_pkg::res_t  res;
  logic             advance;
  logic             fire;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_code_r <= i2cee_pkg::DEVICE_CODE_RST;
    end else if (cfg_wr) begin
      device_code_r <= cfg_data;
    end
  end

  // result slot frees when empty or taken this cycle
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{action: in_action, mem_address: in_mem_address,
                  write_byte: in_write_byte, byte_count: in_byte_count,
                  sda_in: in_sda_in};
    end
  end

  i2cee_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (item_r),
    .device_code (device_code_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_scl_level     = res_r.scl_level;
  assign out_sda_pull_low  = res_r.sda_pull_low;
  assign out_busy_res      = res_r.busy_res;
  assign out_data_request  = res_r.data_request;
  assign out_read_valid    = res_r.read_valid;
  assign out_read_data     = res_r.read_data;
  assign out_last_of_burst = res_r.last_of_burst;

  a_fire_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed item did not reach the result register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r)
    else $error("input stalled with room downstream");

  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_level && !out_sda_pull_low && !out_read_valid)
    else $error("idle result drives the bus");

  a_req_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data_request && out_read_valid))
    else $error("data request and read byte in one phase");

endmodule
